[hw/rtl/boot_progress_stall_watchdog_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the boot progress stall watchdog
// Shared forms for the concurrent checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef BOOT_PROGRESS_STALL_WATCHDOG_CORE_ASSERT_SVH
`define BOOT_PROGRESS_STALL_WATCHDOG_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPSW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpsw assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BPSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpsw assertion failed");

`endif

[hw/rtl/bpsw_pkg.sv]
// ----------------------------------------------------------------------------
// Boot progress stall watchdog package
// Widths, phase and cause codes, and types shared by the watchdog files.
// ----------------------------------------------------------------------------
package bpsw_pkg;

   localparam int COLUMN_BITS_DEFAULT = 10;
   localparam int MESH_BITS_DEFAULT   = 12;

   localparam int PHASE_W = 2;
   localparam int PCT_W   = 7;
   localparam int CAUSE_W = 2;
   localparam int CNT_W   = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [PHASE_W-1:0] PH_GENERATING = 2'd0;
   localparam logic [PHASE_W-1:0] PH_BUILDING   = 2'd1;
   localparam logic [PHASE_W-1:0] PH_READY      = 2'd2;
   localparam logic [PHASE_W-1:0] PH_STALLED    = 2'd3;

   localparam logic [CAUSE_W-1:0] CAUSE_NONE        = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_GEN_STOPPED = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_RING        = 2'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_NO_PROGRESS = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_GRACE_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STALL_TICKS = 1'd1;

   localparam logic [CNT_W-1:0] GRACE_TICKS_RESET = 16'd60;
   localparam logic [CNT_W-1:0] STALL_TICKS_RESET = 16'd180;
   localparam logic [CNT_W-1:0] CNT_MAX           = 16'hFFFF;
   localparam logic [PCT_W-1:0] PCT_FULL          = 7'd100;

   // Status of the shared divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[hw/rtl/bpsw_req_if.sv]
// ----------------------------------------------------------------------------
// Progress sample channel
// Valid/ready channel that carries one progress sample per beat.
// ----------------------------------------------------------------------------
interface bpsw_req_if
   import bpsw_pkg::*;
#(
   parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT,
   parameter int MESH_BITS   = MESH_BITS_DEFAULT
) ();
   logic                   valid;
   logic                   ready;
   logic [COLUMN_BITS-1:0] cols_done;
   logic [COLUMN_BITS-1:0] cols_expected;
   logic [MESH_BITS-1:0]   meshes;
   logic [MESH_BITS-1:0]   mesh_pending;
   logic                   spawn_seen;
   logic                   ring_done;
   logic                   gen_active;

   modport source (
      output valid, cols_done, cols_expected, meshes, mesh_pending,
             spawn_seen, ring_done, gen_active,
      input  ready
   );

   modport sink (
      input  valid, cols_done, cols_expected, meshes, mesh_pending,
             spawn_seen, ring_done, gen_active,
      output ready
   );
endinterface

[hw/rtl/bpsw_rsp_if.sv]
// ----------------------------------------------------------------------------
// Watchdog status channel
// Valid/ready channel that carries phase, percentage and cause per beat.
// ----------------------------------------------------------------------------
interface bpsw_rsp_if
   import bpsw_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [PHASE_W-1:0] phase;
   logic [PCT_W-1:0]   percent;
   logic [CAUSE_W-1:0] stall_cause;

   modport source (
      output valid, phase, percent, stall_cause,
      input  ready
   );

   modport sink (
      input  valid, phase, percent, stall_cause,
      output ready
   );
endinterface

[hw/rtl/bpsw_divider.sv]
// ----------------------------------------------------------------------------
// Shared restoring divider
// Radix-2 divider that produces a PCT_W bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module bpsw_divider
   import bpsw_pkg::*;
#(
   parameter int DIVIDEND_W = 17,
   parameter int DIVISOR_W  = 13
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output div_stat_type          stat,
   output logic [PCT_W-1:0]      quotient
);

   localparam int STEP_W = (PCT_W > 1) ? $clog2(PCT_W) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PCT_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [PCT_W-1:0]      low_ff, low_in;
   logic [PCT_W-1:0]      quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;

   logic [DIVIDEND_W-1:0] dvd_high;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // The caller guarantees a quotient below 2**PCT_W, so the upper dividend
   // bits alone are already smaller than the divisor and seed the remainder.
   assign dvd_high = dividend >> PCT_W;
   assign shifted  = {rem_ff, low_ff[PCT_W-1]};
   assign diff     = shifted - {1'b0, dvs_ff};
   assign fits     = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = dvd_high[DIVISOR_W-1:0];
         low_in  = dividend[PCT_W-1:0];
         quot_in = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         low_in  = low_ff << 1;
         quot_in = {quot_ff[PCT_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule

[hw/rtl/boot_progress_stall_watchdog_core.sv]
// Boot progress stall watchdog core: sequence, flow and reset
// A sample that updates the percentage runs two 7-step divisions on the shared
// divider, one for the column term and one for the mesh term; a division whose
// divisor is zero is skipped. A terminal or stall outcome goes straight to posting.
// One sample in flight; the next is taken in the cycle after the result is posted.
// Synchronous reset restores generating phase, zero counters and register defaults.
module boot_progress_stall_watchdog_core
   import bpsw_pkg::*;
#(
   parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT,
   parameter int MESH_BITS   = MESH_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   bpsw_req_if.sink             req,
   bpsw_rsp_if.source           rsp,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

`include "boot_progress_stall_watchdog_core_assert.svh"

   // Divider sizing. The column term is min(in, total) * 80 over total and
   // the mesh term is meshes * 20 over (meshes + queued); both quotients stay
   // far below 128, so the divider only has to resolve PCT_W quotient bits.
   localparam int COL_DVD_W  = COLUMN_BITS + 7;
   localparam int MESH_DVD_W = MESH_BITS + 5;
   localparam int DVD_W      = (COL_DVD_W > MESH_DVD_W) ? COL_DVD_W : MESH_DVD_W;
   localparam int MTOT_W     = MESH_BITS + 1;
   localparam int DVS_W      = (COLUMN_BITS > MTOT_W) ? COLUMN_BITS : MTOT_W;
   localparam int PROG_W     = COLUMN_BITS + MESH_BITS;

   // Sequencer codes.
   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] S_IDLE      = 3'd0;
   localparam logic [ST_W-1:0] S_COL       = 3'd1;
   localparam logic [ST_W-1:0] S_COL_WAIT  = 3'd2;
   localparam logic [ST_W-1:0] S_MESH      = 3'd3;
   localparam logic [ST_W-1:0] S_MESH_WAIT = 3'd4;
   localparam logic [ST_W-1:0] S_POST      = 3'd5;

   // Configuration registers.
   logic [CNT_W-1:0] grace_ff, grace_in;
   logic [CNT_W-1:0] stall_ff, stall_in;

   // Watchdog state.
   logic [ST_W-1:0]    state_ff, state_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [PCT_W-1:0]   mark_ff, mark_in;
   logic [CAUSE_W-1:0] cause_ff, cause_in;
   logic [CNT_W-1:0]   tick_ff, tick_in;
   logic [CNT_W-1:0]   idle_ff, idle_in;
   logic [PROG_W-1:0]  last_ff, last_in;
   logic               seen_ff, seen_in;

   // Sample held for the divisions, and the column quotient.
   logic [COLUMN_BITS-1:0] cin_ff, cin_in;
   logic [COLUMN_BITS-1:0] ctot_ff, ctot_in;
   logic [MESH_BITS-1:0]   msh_ff, msh_in;
   logic [MESH_BITS-1:0]   mq_ff, mq_in;
   logic [PCT_W-1:0]       qcol_ff, qcol_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0] rsp_phase_ff, rsp_phase_in;
   logic [PCT_W-1:0]   rsp_pct_ff, rsp_pct_in;
   logic [CAUSE_W-1:0] rsp_cause_ff, rsp_cause_in;

   // Shared divider hookup.
   logic               div_start;
   logic [DVD_W-1:0]   div_dividend;
   logic [DVS_W-1:0]   div_divisor;
   div_stat_type       div_stat;
   logic [PCT_W-1:0]   div_quot;

   // Accept-cycle decision terms.
   logic               req_fire;
   logic               terminal;
   logic [CNT_W-1:0]   tick_next;
   logic [CNT_W-1:0]   idle_next;
   logic [PROG_W-1:0]  progress;
   logic               changed;
   logic               ready_hit;
   logic               past_grace;

   // Percentage terms.
   logic [COLUMN_BITS-1:0] col_clamped;
   logic [COL_DVD_W-1:0]   col_dvd;
   logic [MESH_DVD_W-1:0]  mesh_dvd;
   logic [MTOT_W-1:0]      mesh_tot;
   logic [PCT_W:0]         pct_sum;
   logic [PCT_W-1:0]       pct_new;

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign terminal  = (phase_ff == PH_READY) || (phase_ff == PH_STALLED);

   // Both counters saturate at their full count.
   assign tick_next  = (tick_ff == CNT_MAX) ? tick_ff : tick_ff + 1'b1;
   assign progress   = {req.cols_done, req.meshes};
   assign changed    = !seen_ff || (progress != last_ff);
   assign idle_next  = changed ? '0 : ((idle_ff == CNT_MAX) ? idle_ff : idle_ff + 1'b1);
   assign ready_hit  = req.spawn_seen && req.ring_done && (req.mesh_pending == '0);
   assign past_grace = tick_next > grace_ff;

   // Constant multiplies are shift-and-add: 80 = 64 + 16, 20 = 16 + 4.
   assign col_clamped = (cin_ff < ctot_ff) ? cin_ff : ctot_ff;
   assign col_dvd     = (COL_DVD_W'(col_clamped) << 6) + (COL_DVD_W'(col_clamped) << 4);
   assign mesh_dvd    = (MESH_DVD_W'(msh_ff) << 4) + (MESH_DVD_W'(msh_ff) << 2);
   assign mesh_tot    = {1'b0, msh_ff} + {1'b0, mq_ff};

   // One divider serves both terms; the sequencer picks the operands.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = DVD_W'(col_dvd);
      div_divisor  = DVS_W'(ctot_ff);
      case (state_ff)
         S_COL: begin
            div_start = (ctot_ff != '0);
         end
         S_MESH: begin
            div_start    = (mesh_tot != '0);
            div_dividend = DVD_W'(mesh_dvd);
            div_divisor  = DVS_W'(mesh_tot);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // The mesh quotient is zero when nothing was built or queued.
   always_comb begin
      if (state_ff == S_MESH_WAIT) begin
         pct_sum = {1'b0, qcol_ff} + {1'b0, div_quot};
      end else begin
         pct_sum = {1'b0, qcol_ff};
      end
      if (pct_sum > {1'b0, PCT_FULL}) begin
         pct_new = PCT_FULL;
      end else begin
         pct_new = pct_sum[PCT_W-1:0];
      end
   end

   always_comb begin
      grace_in     = grace_ff;
      stall_in     = stall_ff;
      state_in     = state_ff;
      phase_in     = phase_ff;
      mark_in      = mark_ff;
      cause_in     = cause_ff;
      tick_in      = tick_ff;
      idle_in      = idle_ff;
      last_in      = last_ff;
      seen_in      = seen_ff;
      cin_in       = cin_ff;
      ctot_in      = ctot_ff;
      msh_in       = msh_ff;
      mq_in        = mq_ff;
      qcol_in      = qcol_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_cause_in = rsp_cause_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_GRACE_TICKS: grace_in = csr_wdata;
            CSR_STALL_TICKS: stall_in = csr_wdata;
            default: begin
               grace_in = grace_ff;
            end
         endcase
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               tick_in  = tick_next;
               state_in = S_POST;
               // Once ready or stalled, only the tick counter moves.
               if (!terminal) begin
                  idle_in = idle_next;
                  if (changed) begin
                     last_in = progress;
                     seen_in = 1'b1;
                  end
                  if (ready_hit) begin
                     phase_in = PH_READY;
                     mark_in  = PCT_FULL;
                  end else if (past_grace && !req.gen_active && !req.spawn_seen) begin
                     phase_in = PH_STALLED;
                     cause_in = CAUSE_GEN_STOPPED;
                  end else if (past_grace && !req.gen_active &&
                               (req.mesh_pending == '0)) begin
                     phase_in = PH_STALLED;
                     cause_in = CAUSE_RING;
                  end else if (idle_next >= stall_ff) begin
                     phase_in = PH_STALLED;
                     cause_in = CAUSE_NO_PROGRESS;
                  end else begin
                     phase_in = req.spawn_seen ? PH_BUILDING : PH_GENERATING;
                     cin_in   = req.cols_done;
                     ctot_in  = req.cols_expected;
                     msh_in   = req.meshes;
                     mq_in    = req.mesh_pending;
                     state_in = S_COL;
                  end
               end
            end
         end
         S_COL: begin
            if (ctot_ff != '0) begin
               state_in = S_COL_WAIT;
            end else begin
               qcol_in  = '0;
               state_in = S_MESH;
            end
         end
         S_COL_WAIT: begin
            if (div_stat.done) begin
               qcol_in  = div_quot;
               state_in = S_MESH;
            end
         end
         S_MESH: begin
            if (mesh_tot != '0) begin
               state_in = S_MESH_WAIT;
            end else begin
               if (pct_new > mark_ff) begin
                  mark_in = pct_new;
               end
               state_in = S_POST;
            end
         end
         S_MESH_WAIT: begin
            if (div_stat.done) begin
               if (pct_new > mark_ff) begin
                  mark_in = pct_new;
               end
               state_in = S_POST;
            end
         end
         S_POST: begin
            // The result register frees up as soon as the last beat is taken.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_phase_in = phase_ff;
               rsp_pct_in   = mark_ff;
               rsp_cause_in = cause_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grace_ff     <= GRACE_TICKS_RESET;
         stall_ff     <= STALL_TICKS_RESET;
         state_ff     <= S_IDLE;
         phase_ff     <= PH_GENERATING;
         mark_ff      <= '0;
         cause_ff     <= CAUSE_NONE;
         tick_ff      <= '0;
         idle_ff      <= '0;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         grace_ff     <= grace_in;
         stall_ff     <= stall_in;
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         mark_ff      <= mark_in;
         cause_ff     <= cause_in;
         tick_ff      <= tick_in;
         idle_ff      <= idle_in;
         last_ff      <= last_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cin_ff       <= cin_in;
      ctot_ff      <= ctot_in;
      msh_ff       <= msh_in;
      mq_ff        <= mq_in;
      qcol_ff      <= qcol_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_pct_ff   <= rsp_pct_in;
      rsp_cause_ff <= rsp_cause_in;
   end

   bpsw_divider #(
      .DIVIDEND_W (DVD_W),
      .DIVISOR_W  (DVS_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.phase       = rsp_phase_ff;
   assign rsp.percent     = rsp_pct_ff;
   assign rsp.stall_cause = rsp_cause_ff;

   // Ready and stalled are terminal phases.
   `BPSW_ASSERT_NEXT(a_ready_holds, clock, reset, phase_ff == PH_READY, phase_ff == PH_READY)
   `BPSW_ASSERT_NEXT(a_stall_holds, clock, reset, phase_ff == PH_STALLED, phase_ff == PH_STALLED)
   // A cause is reported exactly when the boot has stalled.
   `BPSW_ASSERT_SAME(a_cause_phase, clock, reset, 1'b1,
      (phase_ff == PH_STALLED) == (cause_ff != CAUSE_NONE))
   // The divider only runs and finishes while the sequencer waits for it.
   `BPSW_ASSERT_SAME(a_div_done_wait, clock, reset, div_stat.busy || div_stat.done,
      (state_ff == S_COL_WAIT) || (state_ff == S_MESH_WAIT))

endmodule
